// ===== rtl/core/icmp_echo_reply_builder_top_defines.svh =====
// Assertion macros shared by the ICMP echo reply builder RTL.
`ifndef ICMP_ECHO_REPLY_BUILDER_TOP_DEFINES_SVH
`define ICMP_ECHO_REPLY_BUILDER_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define IERB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define IERB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ierb_pkg.sv =====
// Package with types, constants and checksum helpers for the ICMP echo reply builder.
package ierb_pkg;

  // Packet store geometry
  localparam int MAX_PACKET_BYTES = 512;
  localparam int STORE_WORDS      = (MAX_PACKET_BYTES + 7) / 8;
  localparam int WORD_AW          = $clog2(STORE_WORDS);
  localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int WCNT_W           = $clog2(STORE_WORDS + 1);

  // Checksum accumulator widths
  localparam int SUM_W    = 24;
  localparam int IP_SUM_W = 19;

  // Protocol constants
  localparam logic [7:0]  IP_VER_IHL           = {4'h4, 4'h5};
  localparam logic [7:0]  ICMP_TYPE_ECHO_REPLY = 8'd0;
  localparam logic [7:0]  IP_PROTO_ICMP        = 8'd1;
  localparam logic [7:0]  RESET_TTL            = 8'd63;
  localparam logic [15:0] MIN_LEN              = 16'd28;

  // Word positions of header fields in the packet store
  localparam logic [WORD_AW-1:0] W_IP_ID     = WORD_AW'(0);
  localparam logic [WORD_AW-1:0] W_IP_ADDR   = WORD_AW'(1);
  localparam logic [WORD_AW-1:0] W_ICMP_HDR  = WORD_AW'(2);
  localparam logic [WORD_AW-1:0] W_ICMP_DATA = WORD_AW'(3);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FLUSH,
    ST_DROP,
    ST_SUM,
    ST_HSUM,
    ST_FOLD,
    ST_OUT
  } state_t;

  // Fold a ones' complement sum to 16 bits and invert it
  function automatic logic [15:0] fold16(input logic [SUM_W-1:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {9'b0, s[23:16]} + {1'b0, s[15:0]};
    s2 = {16'b0, s1[16]} + {1'b0, s1[15:0]};
    return ~s2[15:0];
  endfunction

endpackage

// ===== rtl/core/icmp_echo_reply_builder_top.sv =====
// Top level of the ICMP echo reply builder: packet store, checksum passes and reply output.
//
// Request words arrive on in_valid/in_ready with in_data, in_last and in_bytes; the
// valid leading bytes of each word are packed into a 64-bit wide packet store. One
// request word is taken per cycle while loading. After the word marked last, the block
// flushes the partial word, then reads the store to sum the ICMP part and capture the
// header fields, then forms the raw IP header sum and folds both checksums. The reply
// then streams out on out_valid/out_ready, one word per cycle while the receiver takes
// them. The single read port of the store sets the cost: every word is loaded once and
// read twice. A malformed or overlong request yields one transaction with out_dropped
// set instead of a reply.
// When the receiver stalls, the output register holds its word and the store read
// stream pauses. A new request is accepted once the last reply word sits in the
// output register. Reset returns the block to loading, clears the byte count and
// overflow flag, and sets the TTL to 63; the store itself is not cleared.
// cfg_wr_en/cfg_wr_data write the reply TTL; write it only while the block is idle.
`include "icmp_echo_reply_builder_top_defines.svh"

module icmp_echo_reply_builder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data,
  input  logic        in_last,
  input  logic [3:0]  in_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data,
  output logic        out_last,
  output logic [3:0]  out_bytes,
  output logic        out_dropped,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import ierb_pkg::*;

  localparam logic [63:0] ALL_ONES = '1;

  state_t state_r, state_nxt;

  // Load side
  logic [CNT_W-1:0] rcv_cnt_r, rcv_cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [63:0]      part_r, part_nxt;
  logic [63:0]      head_r, head_nxt;
  logic [7:0]       ttl_r;

  // Reply geometry
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [WCNT_W-1:0] words_r, words_nxt;

  // Store read stream
  logic [WCNT_W-1:0]  rd_k_r, rd_k_nxt;
  logic [WORD_AW-1:0] q_k_r, q_k_nxt;
  logic               q_valid_r, q_valid_nxt;
  logic [63:0]        mem_q_r;
  logic [63:0]        store_mem [STORE_WORDS];

  // Checksums and captured header fields
  logic [SUM_W-1:0]    icmp_sum_r, icmp_sum_nxt;
  logic [IP_SUM_W-1:0] ip_sum_r, ip_sum_nxt;
  logic [15:0]         icmp_ck_r, icmp_ck_nxt;
  logic [15:0]         ip_ck_r, ip_ck_nxt;
  logic [15:0]         id_r, id_nxt;
  logic [31:0]         src_r, src_nxt;
  logic [31:0]         dst_r, dst_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;
  logic [3:0]  out_bytes_r, out_bytes_nxt;
  logic        out_drop_r, out_drop_nxt;

  // Phase controls
  logic in_ready_c, flush_c, sum_phase_c, out_phase_c, drop_phase_c, rd_phase_c;

  // Combinational datapath
  logic [3:0]         n_c, take_c;
  logic [CNT_W-1:0]   room_c;
  logic               ovf_hit_c, in_acc_c, spill_c;
  logic [2:0]         fill_c;
  logic [63:0]        part_mask_c, data_mask_c;
  logic [127:0]       merged_c;
  logic               wr_en_c, rd_en_c;
  logic [WORD_AW-1:0] wr_addr_c;
  logic [63:0]        wr_data_c;
  logic [15:0]        hdr_len_c;
  logic               drop_c;
  logic               consume_c, load_rep_c, load_drop_c;
  logic [CNT_W-1:0]   base_q_c, rem_c;
  logic [17:0]        word_sum_c;
  logic [3:0]         cnt_c;
  logic               last_c;
  logic [63:0]        reply_word_c, out_mask_c;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (in_acc_c && in_last) state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = drop_c ? ST_DROP : ST_SUM;
      ST_DROP:  if (load_drop_c) state_nxt = ST_LOAD;
      ST_SUM:   if ((rd_k_r == words_r) && !q_valid_r) state_nxt = ST_HSUM;
      ST_HSUM:  state_nxt = ST_FOLD;
      ST_FOLD:  state_nxt = ST_OUT;
      ST_OUT:   if (load_rep_c && last_c) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // Phase decode
  always_comb begin
    in_ready_c   = 1'b0;
    flush_c      = 1'b0;
    sum_phase_c  = 1'b0;
    out_phase_c  = 1'b0;
    drop_phase_c = 1'b0;
    case (state_r)
      ST_LOAD:  in_ready_c   = 1'b1;
      ST_FLUSH: flush_c      = 1'b1;
      ST_DROP:  drop_phase_c = 1'b1;
      ST_SUM:   sum_phase_c  = 1'b1;
      ST_OUT:   out_phase_c  = 1'b1;
      default:  ;
    endcase
  end

  assign rd_phase_c = sum_phase_c || out_phase_c;

  // Pack incoming bytes behind the partial word
  always_comb begin
    n_c         = (in_bytes > 4'd8) ? 4'd8 : in_bytes;
    room_c      = CNT_W'(MAX_PACKET_BYTES) - rcv_cnt_r;
    ovf_hit_c   = CNT_W'(n_c) > room_c;
    take_c      = ovf_hit_c ? room_c[3:0] : n_c;
    fill_c      = rcv_cnt_r[2:0];
    part_mask_c = ~(ALL_ONES >> {fill_c, 3'b000});
    data_mask_c = ~(ALL_ONES >> {take_c, 3'b000});
    merged_c    = {part_r & part_mask_c, 64'd0} |
                  ({in_data & data_mask_c, 64'd0} >> {fill_c, 3'b000});
    spill_c     = ({1'b0, fill_c} + take_c) >= 4'd8;
    in_acc_c    = in_valid && in_ready_c;
    wr_en_c     = (in_acc_c && spill_c) || (flush_c && (fill_c != 3'd0));
    wr_addr_c   = rcv_cnt_r[3 +: WORD_AW];
    wr_data_c   = flush_c ? (part_r & part_mask_c) : merged_c[127:64];
  end

  // Validate the request at flush time
  always_comb begin
    hdr_len_c = head_r[47:32];
    drop_c    = ovf_r || (rcv_cnt_r < CNT_W'(4)) || (hdr_len_c < MIN_LEN) ||
                (hdr_len_c > 16'(rcv_cnt_r));
  end

  // Read stream control: issue when the data slot is free or being drained
  always_comb begin
    consume_c   = sum_phase_c ? q_valid_r :
                  (out_phase_c && q_valid_r && (!out_valid_r || out_ready));
    rd_en_c     = rd_phase_c && (rd_k_r < words_r) && (!q_valid_r || consume_c);
    load_rep_c  = out_phase_c && consume_c;
    load_drop_c = drop_phase_c && (!out_valid_r || out_ready);
  end

  // Sum the ICMP bytes of the word in the data slot, masked at the packet end
  always_comb begin
    logic [7:0] hi_b;
    logic [7:0] lo_b;
    base_q_c   = CNT_W'({q_k_r, 3'b000});
    word_sum_c = '0;
    for (int h = 0; h < 4; h++) begin
      hi_b = ((base_q_c + CNT_W'(2 * h)) < len_r) ? mem_q_r[63 - 16 * h -: 8] : 8'h00;
      lo_b = ((base_q_c + CNT_W'(2 * h + 1)) < len_r) ? mem_q_r[55 - 16 * h -: 8] : 8'h00;
      word_sum_c = word_sum_c + {2'b00, hi_b, lo_b};
    end
  end

  // Build the reply word for the data slot
  always_comb begin
    rem_c      = len_r - base_q_c;
    cnt_c      = (rem_c >= CNT_W'(8)) ? 4'd8 : rem_c[3:0];
    last_c     = (WCNT_W'(q_k_r) + WCNT_W'(1)) == words_r;
    out_mask_c = ~(ALL_ONES >> {cnt_c, 3'b000});
    if (q_k_r == W_IP_ID) begin
      reply_word_c = {IP_VER_IHL, 8'h00, 16'(len_r), id_r, 16'h0000};
    end else if (q_k_r == W_IP_ADDR) begin
      reply_word_c = {ttl_r, IP_PROTO_ICMP, ip_ck_r, dst_r};
    end else if (q_k_r == W_ICMP_HDR) begin
      reply_word_c = {src_r, ICMP_TYPE_ECHO_REPLY, 8'h00, icmp_ck_r};
    end else begin
      reply_word_c = mem_q_r;
    end
  end

  // Register next values
  always_comb begin
    rcv_cnt_nxt   = rcv_cnt_r;
    ovf_nxt       = ovf_r;
    part_nxt      = part_r;
    head_nxt      = head_r;
    len_nxt       = len_r;
    words_nxt     = words_r;
    rd_k_nxt      = rd_k_r;
    q_k_nxt       = q_k_r;
    q_valid_nxt   = q_valid_r;
    icmp_sum_nxt  = icmp_sum_r;
    ip_sum_nxt    = ip_sum_r;
    icmp_ck_nxt   = icmp_ck_r;
    ip_ck_nxt     = ip_ck_r;
    id_nxt        = id_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_bytes_nxt = out_bytes_r;
    out_drop_nxt  = out_drop_r;

    // Append accepted bytes
    if (in_acc_c) begin
      rcv_cnt_nxt = rcv_cnt_r + CNT_W'(take_c);
      ovf_nxt     = ovf_r | ovf_hit_c;
      part_nxt    = spill_c ? merged_c[63:0] : merged_c[127:64];
      if (rcv_cnt_r[CNT_W-1:3] == '0) head_nxt = merged_c[127:64];
    end

    // Latch reply geometry and restart the load counters
    if (flush_c) begin
      rcv_cnt_nxt  = '0;
      ovf_nxt      = 1'b0;
      len_nxt      = hdr_len_c[CNT_W-1:0];
      words_nxt    = WCNT_W'((17'(hdr_len_c) + 17'd7) >> 3);
      rd_k_nxt     = '0;
      icmp_sum_nxt = '0;
    end

    // Advance the read stream
    if (rd_en_c) begin
      rd_k_nxt    = rd_k_r + WCNT_W'(1);
      q_k_nxt     = rd_k_r[WORD_AW-1:0];
      q_valid_nxt = 1'b1;
    end else if (consume_c) begin
      q_valid_nxt = 1'b0;
    end

    // Accumulate the ICMP sum and capture header fields
    if (sum_phase_c && q_valid_r) begin
      if (q_k_r >= W_ICMP_DATA) icmp_sum_nxt = icmp_sum_r + SUM_W'(word_sum_c);
      if (q_k_r == W_IP_ID)     id_nxt  = mem_q_r[31:16];
      if (q_k_r == W_IP_ADDR)   src_nxt = mem_q_r[31:0];
      if (q_k_r == W_ICMP_HDR)  dst_nxt = mem_q_r[63:32];
    end

    // Raw IP header sum over the rebuilt header
    if (state_r == ST_HSUM) begin
      ip_sum_nxt = IP_SUM_W'({IP_VER_IHL, 8'h00}) + IP_SUM_W'(len_r) + IP_SUM_W'(id_r) +
                   IP_SUM_W'({ttl_r, IP_PROTO_ICMP}) + IP_SUM_W'(src_r[31:16]) +
                   IP_SUM_W'(src_r[15:0]) + IP_SUM_W'(dst_r[31:16]) +
                   IP_SUM_W'(dst_r[15:0]);
    end

    // Fold both checksums and rewind the read stream
    if (state_r == ST_FOLD) begin
      ip_ck_nxt   = fold16(SUM_W'(ip_sum_r));
      icmp_ck_nxt = fold16(icmp_sum_r);
      rd_k_nxt    = '0;
    end

    // Output register: load a reply word or the drop marker, else drain
    if (load_rep_c) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = reply_word_c & out_mask_c;
      out_last_nxt  = last_c;
      out_bytes_nxt = cnt_c;
      out_drop_nxt  = 1'b0;
    end else if (load_drop_c) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_last_nxt  = 1'b1;
      out_bytes_nxt = 4'd1;
      out_drop_nxt  = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      rcv_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      rd_k_r      <= '0;
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ttl_r       <= RESET_TTL;
    end else begin
      state_r     <= state_nxt;
      rcv_cnt_r   <= rcv_cnt_nxt;
      ovf_r       <= ovf_nxt;
      rd_k_r      <= rd_k_nxt;
      q_valid_r   <= q_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) ttl_r <= cfg_wr_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    part_r      <= part_nxt;
    head_r      <= head_nxt;
    len_r       <= len_nxt;
    words_r     <= words_nxt;
    q_k_r       <= q_k_nxt;
    icmp_sum_r  <= icmp_sum_nxt;
    ip_sum_r    <= ip_sum_nxt;
    icmp_ck_r   <= icmp_ck_nxt;
    ip_ck_r     <= ip_ck_nxt;
    id_r        <= id_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  // Packet store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en_c) store_mem[wr_addr_c] <= wr_data_c;
    if (rd_en_c) mem_q_r <= store_mem[rd_k_r[WORD_AW-1:0]];
  end

  assign in_ready    = in_ready_c;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;
  assign out_last    = out_last_r;
  assign out_bytes   = out_bytes_r;
  assign out_dropped = out_drop_r;

  // Checks
  `IERB_ASSERT_NOW(a_wr_while_loading, wr_en_c, (state_r == ST_LOAD) || (state_r == ST_FLUSH), "store written outside load or flush")
  `IERB_ASSERT_NOW(a_no_rw_overlap, rd_en_c, !wr_en_c, "store read and written in one cycle")
  `IERB_ASSERT_NOW(a_slot_in_pass, q_valid_r, (state_r == ST_SUM) || (state_r == ST_OUT), "read data pending outside a read pass")
  `IERB_ASSERT_NEXT(a_flush_restarts, state_r == ST_FLUSH, (rcv_cnt_r == '0) && !ovf_r, "load counters not cleared after flush")
  `IERB_ASSERT_NOW(a_inner_word_full, out_valid && !out_last, (out_bytes == 4'd8) && !out_dropped, "short reply word before the last")

endmodule

// ===== dv/tb_icmp_echo_reply_builder_top.sv =====
// Self-checking testbench for the ICMP echo reply builder: directed packets, then random traffic.
module tb_icmp_echo_reply_builder_top;
  import ierb_pkg::*;

  localparam int MAX_FRAME     = 600;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 16;

  typedef enum logic [1:0] {CH_FULL, CH_RANDOM, CH_EDGE} chunk_mode_t;
  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_mode_t;
  typedef enum logic [1:0] {PACE_FREE, PACE_THREE_IN_FOUR, PACE_COIN, PACE_TRICKLE} pace_mode_t;

  typedef struct packed {
    logic [63:0] data;
    logic        last;
    logic [3:0]  nbytes;
    logic        dropped;
  } reply_word_t;

  typedef struct packed {
    logic [15:0] len_field;
    logic [9:0]  total;
    chunk_mode_t mode;
    fill_mode_t  fill;
    logic        typed_drop;
  } pkt_row_t;

  localparam reply_word_t REJECT_WORD = '{data: 64'h0, last: 1'b1, nbytes: 4'd1, dropped: 1'b1};

  // Directed packets: rows marked typed_drop carry the rejection word as expectation
  localparam int N_ROWS = 6;
  pkt_row_t directed_rows [N_ROWS] = '{
    '{16'd28,    10'd28, CH_FULL, FILL_ZERO,   1'b0},  // shortest legal request, zero data
    '{16'd27,    10'd32, CH_FULL, FILL_ONES,   1'b1},  // length one below the minimum
    '{16'd40,    10'd36, CH_FULL, FILL_RANDOM, 1'b1},  // length beyond the bytes received
    '{16'd0,     10'd3,  CH_FULL, FILL_RANDOM, 1'b1},  // too short to carry a length
    '{16'd33,    10'd33, CH_EDGE, FILL_ONES,   1'b0},  // odd length, empty and oversize counts
    '{16'hFFFF,  10'd30, CH_FULL, FILL_RANDOM, 1'b1}   // largest length field
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data = 64'h0;
  logic        in_last = 1'b0;
  logic [3:0]  in_bytes = 4'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_data;
  logic        out_last;
  logic [3:0]  out_bytes;
  logic        out_dropped;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h0;

  // Predictor state
  logic [7:0]  req_bytes [MAX_PACKET_BYTES];
  logic [7:0]  echo_img [MAX_PACKET_BYTES];
  int unsigned rx_count = 0;
  bit          rx_overflow = 1'b0;
  logic [7:0]  ttl_shadow = RESET_TTL;
  reply_word_t predicted_words [$];
  reply_word_t expected_reply_words [$];

  // Stimulus state
  logic [7:0]  frame_bytes [MAX_FRAME];
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned pace_cycle = 0;
  pace_mode_t  pace_mode = PACE_FREE;

  always #5 clk = ~clk;

  icmp_echo_reply_builder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .in_last     (in_last),
    .in_bytes    (in_bytes),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .out_last    (out_last),
    .out_bytes   (out_bytes),
    .out_dropped (out_dropped),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Ones' complement checksum over echo_img, odd byte padded with a zero low byte
  function automatic logic [15:0] inet_checksum(input int unsigned first,
                                                input int unsigned count);
    int unsigned acc;
    int unsigned i;
    acc = 0;
    for (i = 0; i + 1 < count; i += 2)
      acc += {echo_img[first + i], echo_img[first + i + 1]};
    if (count % 2 == 1)
      acc += {echo_img[first + count - 1], 8'h00};
    acc = (acc >> 16) + (acc & 32'hFFFF);
    acc += acc >> 16;
    return ~acc[15:0];
  endfunction

  // Append one request word and, on the last word, build the reply words or the rejection word
  task automatic predict_echo_reply(input logic [63:0] d, input logic l, input logic [3:0] n);
    int unsigned take;
    int unsigned k;
    int unsigned j;
    int unsigned plen;
    int unsigned nw;
    int unsigned cnt;
    logic [15:0] ck;
    logic [7:0]  tmp;
    reply_word_t w;
    take = (n > 8) ? 8 : n;
    for (k = 0; k < take; k++) begin
      if (rx_count >= MAX_PACKET_BYTES) begin
        rx_overflow = 1'b1;
      end else begin
        req_bytes[rx_count] = d[63 - 8 * k -: 8];
        rx_count++;
      end
    end
    if (!l) return;
    plen = (rx_count >= 4) ? {req_bytes[2], req_bytes[3]} : 0;
    if (rx_overflow || plen < MIN_LEN || plen > rx_count) begin
      predicted_words.push_back(REJECT_WORD);
    end else begin
      for (k = 0; k < plen; k++) echo_img[k] = req_bytes[k];
      // turn the ICMP header into a reply and checksum the ICMP part
      echo_img[20] = ICMP_TYPE_ECHO_REPLY;
      echo_img[21] = 8'h00;
      echo_img[22] = 8'h00;
      echo_img[23] = 8'h00;
      ck = inet_checksum(20, plen - 20);
      echo_img[22] = ck[15:8];
      echo_img[23] = ck[7:0];
      // rebuild the IP header with swapped addresses
      for (k = 0; k < 4; k++) begin
        tmp = echo_img[12 + k];
        echo_img[12 + k] = echo_img[16 + k];
        echo_img[16 + k] = tmp;
      end
      echo_img[0]  = IP_VER_IHL;
      echo_img[1]  = 8'h00;
      echo_img[6]  = 8'h00;
      echo_img[7]  = 8'h00;
      echo_img[8]  = ttl_shadow;
      echo_img[9]  = IP_PROTO_ICMP;
      echo_img[10] = 8'h00;
      echo_img[11] = 8'h00;
      ck = inet_checksum(0, 20);
      echo_img[10] = ck[15:8];
      echo_img[11] = ck[7:0];
      // pack the reply into words, trailing bytes zero
      nw = (plen + 7) / 8;
      for (k = 0; k < nw; k++) begin
        cnt = plen - 8 * k;
        if (cnt > 8) cnt = 8;
        w.data = 64'h0;
        for (j = 0; j < cnt; j++) w.data[63 - 8 * j -: 8] = echo_img[8 * k + j];
        w.last    = (k + 1 == nw);
        w.nbytes  = cnt[3:0];
        w.dropped = 1'b0;
        predicted_words.push_back(w);
      end
    end
    rx_count    = 0;
    rx_overflow = 1'b0;
  endtask

  // Offer one request word, wait for the transaction, then maybe idle
  task automatic push_word(input logic [63:0] d, input logic l, input logic [3:0] n,
                           input bit typed_drop);
    in_valid <= 1'b1;
    in_data  <= d;
    in_last  <= l;
    in_bytes <= n;
    do @(posedge clk); while (!in_ready);
    predict_echo_reply(d, l, n);
    if (typed_drop && l) begin
      predicted_words.delete();
      expected_reply_words.push_back(REJECT_WORD);
    end else begin
      while (predicted_words.size() != 0)
        expected_reply_words.push_back(predicted_words.pop_front());
    end
    words_sent++;
    // end the burst with a random gap
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Split a request frame into words according to the chunking mode
  task automatic send_packet(input int unsigned len_field, input int unsigned total,
                             input chunk_mode_t mode, input fill_mode_t fill,
                             input bit typed_drop);
    int unsigned pos;
    int unsigned cnt;
    int unsigned i;
    logic [63:0] d;
    logic [3:0]  nb;
    logic        fin;
    for (i = 0; i < total; i++) begin
      case (fill)
        FILL_ZERO: frame_bytes[i] = 8'h00;
        FILL_ONES: frame_bytes[i] = 8'hFF;
        default:   frame_bytes[i] = 8'($urandom);
      endcase
    end
    if (total >= 4) begin
      frame_bytes[2] = len_field[15:8];
      frame_bytes[3] = len_field[7:0];
    end
    // lead with an empty word in edge mode
    if (mode == CH_EDGE) push_word({$urandom, $urandom}, 1'b0, 4'd0, 1'b0);
    pos = 0;
    while (pos < total) begin
      cnt = (mode == CH_RANDOM) ? $urandom_range(1, 8) : 8;
      if (cnt > total - pos) cnt = total - pos;
      d = {$urandom, $urandom};
      for (i = 0; i < cnt; i++) d[63 - 8 * i -: 8] = frame_bytes[pos + i];
      nb = cnt[3:0];
      // oversize count on the first full word in edge mode
      if (mode == CH_EDGE && cnt == 8 && pos == 0) nb = 4'($urandom_range(9, 15));
      pos += cnt;
      fin = (pos >= total) && (mode != CH_EDGE);
      push_word(d, fin, nb, typed_drop);
    end
    // close with an empty last word in edge mode
    if (mode == CH_EDGE) push_word({$urandom, $urandom}, 1'b1, 4'd0, typed_drop);
  endtask

  // Hold the sender until every reply has arrived and the block is idle
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (expected_reply_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    ttl_shadow = v;
  endtask

  // Mostly well-formed requests with random content, plus malformed ones
  task automatic run_random_phase(input int unsigned budget, input bit with_full,
                                  input bit with_overflow);
    int unsigned start;
    int unsigned r;
    int unsigned plen;
    int unsigned sent;
    chunk_mode_t mode;
    fill_mode_t  fill;
    if (with_full)
      send_packet(MAX_PACKET_BYTES, MAX_PACKET_BYTES, CH_FULL, FILL_RANDOM, 1'b0);
    if (with_overflow)
      send_packet($urandom_range(MIN_LEN, MAX_PACKET_BYTES),
                  MAX_PACKET_BYTES + $urandom_range(1, 8), CH_FULL, FILL_RANDOM, 1'b1);
    start = words_sent;
    while (words_sent - start < budget) begin
      r = $urandom_range(0, 9);
      mode = (r < 6) ? CH_FULL : (r < 9) ? CH_RANDOM : CH_EDGE;
      r = $urandom_range(0, 9);
      fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RANDOM;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        plen = (r < 60) ? $urandom_range(MIN_LEN, 72) : $urandom_range(73, 200);
        sent = ($urandom_range(0, 3) == 0) ? plen + $urandom_range(1, 12) : plen;
        if (plen > 72) mode = CH_FULL;
      end else if (r < 80) begin
        plen = $urandom_range(0, MIN_LEN - 1);
        sent = $urandom_range(4, 40);
      end else if (r < 90) begin
        sent = $urandom_range(4, 60);
        plen = $urandom_range(sent + 1, 16'hFFFF);
      end else begin
        plen = $urandom_range(0, 16'hFFFF);
        sent = $urandom_range(1, 3);
      end
      send_packet(plen, sent, mode, fill, 1'b0);
    end
  endtask

  function automatic void note_mismatch(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("reply mismatch on %s: expected %h, got %h at %0t", field, want, got, $time);
  endfunction

  // Receiver pacing: switch among free, three-in-four, coin-flip and trickle stall patterns
  always @(posedge clk) begin
    pace_cycle <= pace_cycle + 1;
    if (pace_cycle % 64 == 0) pace_mode <= pace_mode_t'($urandom_range(0, 3));
    case (pace_mode)
      PACE_FREE:          out_ready <= 1'b1;
      PACE_THREE_IN_FOUR: out_ready <= (pace_cycle % 4 != 3);
      PACE_COIN:          out_ready <= 1'($urandom_range(0, 1));
      default:            out_ready <= (pace_cycle % 16 < 4);
    endcase
  end

  // Compare each reply transaction with the oldest expectation
  always @(posedge clk) begin : reply_monitor
    reply_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reply_words.size() == 0) begin
        note_mismatch("unexpected reply word", 64'h0, out_data);
      end else begin
        want = expected_reply_words.pop_front();
        if (out_data !== want.data) note_mismatch("out_data", want.data, out_data);
        if (out_last !== want.last) note_mismatch("out_last", 64'(want.last), 64'(out_last));
        if (out_bytes !== want.nbytes)
          note_mismatch("out_bytes", 64'(want.nbytes), 64'(out_bytes));
        if (out_dropped !== want.dropped)
          note_mismatch("out_dropped", 64'(want.dropped), 64'(out_dropped));
      end
    end
  end

  initial begin : stimulus
    int unsigned row;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // directed packets with the reset TTL
    for (row = 0; row < N_ROWS; row++)
      send_packet(directed_rows[row].len_field, directed_rows[row].total,
                  directed_rows[row].mode, directed_rows[row].fill,
                  directed_rows[row].typed_drop);
    drain_replies();
    write_ttl(8'h00);
    run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
    drain_replies();
    write_ttl(8'hFF);
    run_random_phase(PHASE_ITEMS, 1'b1, 1'b0);
    drain_replies();
    write_ttl(8'($urandom_range(1, 254)));
    run_random_phase(PHASE_ITEMS, 1'b0, 1'b1);
    drain_replies();
    if (mismatch_count == 0 && expected_reply_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
